### rtl/smbu_pkg.sv
// shared types, codes and helpers for the sorted merge bag union
`default_nettype none
package smbu_pkg;

	localparam int KEY_BYTES   = 8;
	localparam int KEY_BITS    = KEY_BYTES * 8;
	localparam int COUNT_BITS  = 32;
	localparam int KEY_W       = 64;
	localparam int GCOUNT_W    = 32;
	localparam int QDEPTH      = 2;
	localparam int QPTR_W      = $clog2(QDEPTH);
	localparam int QCNT_W      = $clog2(QDEPTH + 1);

	typedef logic [KEY_BITS-1:0]   hkey_t;
	typedef logic [COUNT_BITS-1:0] count_t;
	typedef logic [QPTR_W-1:0]     qptr_t;
	typedef logic [QCNT_W-1:0]     qcnt_t;

	typedef enum logic [1:0] {
		OP_KEY1 = 2'd0,
		OP_KEY2 = 2'd1,
		OP_END1 = 2'd2,
		OP_END2 = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		NEED_FIRST  = 2'd0,
		NEED_SECOND = 2'd1,
		NEED_NONE   = 2'd2
	} need_t;

	// what the front hands to the back for one request
	typedef struct packed {
		logic  err;
		logic  take;
		hkey_t key;
		logic  done;
		need_t need;
	} cmd_t;

	typedef struct packed {
		logic         group_valid;
		logic [KEY_W-1:0]    group_key;
		logic [GCOUNT_W-1:0] group_count;
		need_t        need;
		logic         done;
		logic         error;
	} res_t;

	function automatic need_t next_need(input logic f_full, input logic f_end,
			input logic s_full, input logic s_end);
		need_t n;
		if (f_end && s_end)
			n = NEED_NONE;
		else if (!f_full && !f_end)
			n = NEED_FIRST;
		else if (!s_full && !s_end)
			n = NEED_SECOND;
		else
			n = NEED_NONE;
		return n;
	endfunction

endpackage
`default_nettype wire

### rtl/smbu_front.sv
// front: holds the two stream heads, checks requests, picks the head to take
`default_nettype none
module smbu_front (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push,
	output logic                 full,
	input  wire logic [1:0]      op,
	input  wire logic [63:0]     key,
	output logic                 cmd_valid,
	output smbu_pkg::cmd_t       cmd,
	input  wire logic            cmd_pop
);
	import smbu_pkg::*;

	logic  f_full_q, f_end_q, s_full_q, s_end_q;
	hkey_t f_key_q, s_key_q;

	cmd_t  cmd_mem_q [QDEPTH];
	qptr_t wr_ptr_q, rd_ptr_q;
	qcnt_t cnt_q;

	logic  accept, to_second, is_end, err;
	logic  a_f_full, a_s_full, a_f_end, a_s_end;
	logic  n_f_full, n_s_full;
	hkey_t in_key, a_f_key, a_s_key;
	logic  take, take_first;
	cmd_t  new_cmd;

	assign full   = (cnt_q == qcnt_t'(QDEPTH));
	assign accept = push && !full;
	assign in_key = hkey_t'(key);

	always_comb begin
		to_second = op inside {OP_KEY2, OP_END2};
		is_end    = op inside {OP_END1, OP_END2};
		err       = to_second ? (s_full_q || s_end_q) : (f_full_q || f_end_q);

		// state with the request applied
		a_f_full = f_full_q || (!is_end && !to_second);
		a_s_full = s_full_q || (!is_end && to_second);
		a_f_end  = f_end_q || (is_end && !to_second);
		a_s_end  = s_end_q || (is_end && to_second);
		a_f_key  = (!is_end && !to_second) ? in_key : f_key_q;
		a_s_key  = (!is_end && to_second) ? in_key : s_key_q;

		take       = (a_f_full || a_f_end) && (a_s_full || a_s_end) && (a_f_full || a_s_full);
		take_first = a_f_full && (!a_s_full || a_f_key <= a_s_key);
		n_f_full   = a_f_full && !(take && take_first);
		n_s_full   = a_s_full && !(take && !take_first);

		new_cmd      = '0;
		new_cmd.err  = err;
		if (err) begin
			new_cmd.need = next_need(f_full_q, f_end_q, s_full_q, s_end_q);
		end else begin
			new_cmd.take = take;
			new_cmd.key  = take_first ? a_f_key : a_s_key;
			new_cmd.done = is_end && a_f_end && a_s_end;
			new_cmd.need = next_need(n_f_full, a_f_end, n_s_full, a_s_end);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			f_full_q <= 1'b0;
			f_end_q  <= 1'b0;
			s_full_q <= 1'b0;
			s_end_q  <= 1'b0;
		end else if (accept && !err) begin
			f_full_q <= n_f_full;
			f_end_q  <= a_f_end;
			s_full_q <= n_s_full;
			s_end_q  <= a_s_end;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && !err) begin
			f_key_q <= a_f_key;
			s_key_q <= a_s_key;
		end
	end

	// request queue toward the back
	always_ff @(posedge clk) begin
		if (accept)
			cmd_mem_q[wr_ptr_q] <= new_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (accept)
				wr_ptr_q <= wr_ptr_q + qptr_t'(1);
			if (cmd_pop)
				rd_ptr_q <= rd_ptr_q + qptr_t'(1);
			if (accept && !cmd_pop)
				cnt_q <= cnt_q + qcnt_t'(1);
			else if (!accept && cmd_pop)
				cnt_q <= cnt_q - qcnt_t'(1);
		end
	end

	assign cmd_valid = (cnt_q != '0);
	assign cmd       = cmd_mem_q[rd_ptr_q];

endmodule
`default_nettype wire

### rtl/smbu_back.sv
// back: folds taken keys into the open group and buffers finished results
`default_nettype none
module smbu_back (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            cmd_valid,
	input  wire smbu_pkg::cmd_t  cmd,
	output logic                 cmd_pop,
	output logic                 res_valid,
	output smbu_pkg::res_t       res,
	input  wire logic            res_pop
);
	import smbu_pkg::*;

	hkey_t  open_key_q;
	count_t open_cnt_q;
	logic   open_q;

	res_t   res_mem_q [QDEPTH];
	qptr_t  wr_ptr_q, rd_ptr_q;
	qcnt_t  cnt_q;

	logic   room, n_open, emit;
	hkey_t  n_key, e_key;
	count_t n_cnt, e_cnt;
	res_t   new_res;

	assign room    = (cnt_q != qcnt_t'(QDEPTH)) || res_pop;
	assign cmd_pop = cmd_valid && room;

	always_comb begin
		n_open = open_q;
		n_key  = open_key_q;
		n_cnt  = open_cnt_q;
		emit   = 1'b0;
		e_key  = '0;
		e_cnt  = '0;
		if (!cmd.err && cmd.take) begin
			if (open_q && cmd.key == open_key_q) begin
				if (open_cnt_q != '1)
					n_cnt = open_cnt_q + count_t'(1);
			end else begin
				emit   = open_q;
				e_key  = open_key_q;
				e_cnt  = open_cnt_q;
				n_key  = cmd.key;
				n_cnt  = count_t'(1);
				n_open = 1'b1;
			end
		end
		// finishing flushes whatever group is open now, replacing any earlier pick
		if (!cmd.err && cmd.done && n_open) begin
			emit   = 1'b1;
			e_key  = n_key;
			e_cnt  = n_cnt;
			n_open = 1'b0;
			n_cnt  = '0;
		end

		new_res             = '0;
		new_res.need        = cmd.need;
		new_res.error       = cmd.err;
		new_res.done        = !cmd.err && cmd.done;
		new_res.group_valid = emit;
		new_res.group_key   = emit ? KEY_W'(e_key) : '0;
		new_res.group_count = emit ? GCOUNT_W'(e_cnt) : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q     <= 1'b0;
			open_cnt_q <= '0;
		end else if (cmd_pop) begin
			open_q     <= n_open;
			open_cnt_q <= n_cnt;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_pop)
			open_key_q <= n_key;
	end

	always_ff @(posedge clk) begin
		if (cmd_pop)
			res_mem_q[wr_ptr_q] <= new_res;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (cmd_pop)
				wr_ptr_q <= wr_ptr_q + qptr_t'(1);
			if (res_pop)
				rd_ptr_q <= rd_ptr_q + qptr_t'(1);
			if (cmd_pop && !res_pop)
				cnt_q <= cnt_q + qcnt_t'(1);
			else if (!cmd_pop && res_pop)
				cnt_q <= cnt_q - qcnt_t'(1);
		end
	end

	assign res_valid = (cnt_q != '0);
	assign res       = res_mem_q[rd_ptr_q];

endmodule
`default_nettype wire

### rtl/sorted_merge_bag_union.sv
// top level of the sorted merge bag union
//
// channel   | handshake          | payload
// ----------+--------------------+-----------------------------------------------
// input     | push / full        | op, key
// result    | empty / pop        | group_valid, group_key, group_count,
//           |                    | need_stream, done_res, error
//
// one request per cycle while neither queue stalls; a taken request waits in the
// request queue, and its result shows once the back moves it to the result queue
// the per-request work is one 64-bit head compare in the front and one key
// compare plus a saturating count add in the back
// both sides hold two entries each, so input and result stalls are absorbed separately
// reset clears the stream flags, the open group and both queues; stored keys are not cleared
`default_nettype none
module sorted_merge_bag_union (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	output logic             full,
	input  wire logic [1:0]  op,
	input  wire logic [63:0] key,
	output logic             empty,
	input  wire logic        pop,
	output logic             group_valid,
	output logic [63:0]      group_key,
	output logic [31:0]      group_count,
	output logic [1:0]       need_stream,
	output logic             done_res,
	output logic             error
);
	import smbu_pkg::*;

	logic cmd_valid, cmd_pop, res_valid, res_pop;
	cmd_t cmd;
	res_t res;

	smbu_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.op        (op),
		.key       (key),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop)
	);

	smbu_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop),
		.res_valid (res_valid),
		.res       (res),
		.res_pop   (res_pop)
	);

	assign empty       = !res_valid;
	assign res_pop     = pop && res_valid;
	assign group_valid = res.group_valid;
	assign group_key   = res.group_key;
	assign group_count = res.group_count;
	assign need_stream = res.need;
	assign done_res    = res.done;
	assign error       = res.error;

endmodule
`default_nettype wire

### rtl/smbu_checker.sv
// port-level checks for the sorted merge bag union, bound to the top level
`default_nettype none
module smbu_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        push,
	input wire logic        full,
	input wire logic [1:0]  op,
	input wire logic [63:0] key,
	input wire logic        empty,
	input wire logic        pop,
	input wire logic        group_valid,
	input wire logic [63:0] group_key,
	input wire logic [31:0] group_count,
	input wire logic [1:0]  need_stream,
	input wire logic        done_res,
	input wire logic        error
);
	import smbu_pkg::*;

	// a dropped request never carries a group or the finish mark
	a_err_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && error) |-> (!group_valid && !done_res && group_key == '0
			&& group_count == '0))
		else $error("dropped request carries a group");

	// finishing leaves nothing to feed
	a_done_need: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && done_res) |-> (need_stream == NEED_NONE))
		else $error("finish result still asks for a stream");

	// an emitted group has at least one copy
	a_group_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && group_valid) |-> (group_count != '0))
		else $error("emitted group with zero count");

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> !empty)
		else $error("waiting result withdrawn");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> ($stable(group_key) && $stable(group_count)
			&& $stable(need_stream) && $stable(error)))
		else $error("waiting result changed");

endmodule

bind sorted_merge_bag_union smbu_checker u_smbu_checker (.*);
`default_nettype wire

### verif/smbu_tb_pkg.sv
// scoreboard class that predicts the bag union results and checks them in order
`timescale 1ns / 1ps
package smbu_tb_pkg;
	import smbu_pkg::*;

	typedef struct {
		logic        grp_valid;
		logic [63:0] grp_key;
		logic [31:0] grp_count;
		need_t       need;
		logic        done;
		logic        err;
	} union_result_t;

	class union_checker;
		hkey_t         head_key [2];
		logic          head_full [2];
		logic          ended [2];
		hkey_t         open_key;
		count_t        open_count;
		logic          group_is_open;
		union_result_t pending_results [$];
		int            mismatches;

		function new();
			for (int s = 0; s < 2; s++) begin
				head_key[s] = '0;
				head_full[s] = 1'b0;
				ended[s] = 1'b0;
			end
			open_key = '0;
			open_count = '0;
			group_is_open = 1'b0;
			mismatches = 0;
		endfunction

		function need_t wanted_stream();
			if (ended[0] && ended[1])
				return NEED_NONE;
			if (!head_full[0] && !ended[0])
				return NEED_FIRST;
			if (!head_full[1] && !ended[1])
				return NEED_SECOND;
			return NEED_NONE;
		endfunction

		function bit holds_key(int s);
			return head_full[s];
		endfunction

		function int pending();
			return pending_results.size();
		endfunction

		// advance the merge by one accepted request and queue what it must produce
		function void note_request(op_t o, logic [63:0] k);
			union_result_t r;
			int            s;
			int            src;
			bit            is_end;
			hkey_t         taken;
			s = (o == OP_KEY2 || o == OP_END2) ? 1 : 0;
			is_end = (o == OP_END1 || o == OP_END2);
			r.grp_valid = 1'b0;
			r.grp_key = '0;
			r.grp_count = '0;
			r.done = 1'b0;
			r.err = 1'b0;
			if (head_full[s] || ended[s]) begin
				r.err = 1'b1;
				r.need = wanted_stream();
				pending_results = {pending_results, r};
				return;
			end
			if (is_end) begin
				ended[s] = 1'b1;
			end else begin
				head_key[s] = k[KEY_BITS-1:0];
				head_full[s] = 1'b1;
			end
			if ((head_full[0] || ended[0]) && (head_full[1] || ended[1]) &&
					(head_full[0] || head_full[1])) begin
				// ties go to the first stream
				src = (head_full[0] && (!head_full[1] || head_key[0] <= head_key[1])) ? 0 : 1;
				taken = head_key[src];
				head_full[src] = 1'b0;
				if (group_is_open && taken == open_key) begin
					if (open_count != '1)
						open_count++;
				end else begin
					if (group_is_open) begin
						r.grp_valid = 1'b1;
						r.grp_key = 64'(open_key);
						r.grp_count = 32'(open_count);
					end
					open_key = taken;
					open_count = 1;
					group_is_open = 1'b1;
				end
			end
			if (is_end && ended[0] && ended[1]) begin
				r.done = 1'b1;
				if (group_is_open) begin
					r.grp_valid = 1'b1;
					r.grp_key = 64'(open_key);
					r.grp_count = 32'(open_count);
					group_is_open = 1'b0;
					open_count = '0;
				end
			end
			r.need = wanted_stream();
			pending_results = {pending_results, r};
		endfunction

		task report_mismatch(string what);
			mismatches++;
			$display("mismatch at %0t: %s", $time, what);
		endtask

		task compare_field(string field_name, logic [63:0] got_v, logic [63:0] want_v);
			if (got_v !== want_v)
				report_mismatch($sformatf("%s is %0h, expected %0h", field_name, got_v, want_v));
		endtask

		task check_result(union_result_t got);
			union_result_t want;
			if (pending_results.size() == 0) begin
				report_mismatch($sformatf("result with no request waiting, group_key %0h",
					got.grp_key));
				return;
			end
			want = pending_results.pop_front();
			compare_field("group_valid", 64'(got.grp_valid), 64'(want.grp_valid));
			compare_field("group_key", got.grp_key, want.grp_key);
			compare_field("group_count", 64'(got.grp_count), 64'(want.grp_count));
			compare_field("need_stream", 64'(got.need), 64'(want.need));
			compare_field("done_res", 64'(got.done), 64'(want.done));
			compare_field("error", 64'(got.err), 64'(want.err));
		endtask
	endclass

endpackage

### verif/tb_top.sv
// top of the merge testbench: clock, reset, request driver, result checks and watchdog
`timescale 1ns / 1ps
module tb_top;
	import smbu_pkg::*;
	import smbu_tb_pkg::*;

	localparam int          RANDOM_KEYS  = 1250;
	localparam int          IDLE_LIMIT   = 4000;
	localparam int          DRAIN_CYCLES = 16;
	localparam logic [63:0] KEY_MAX      = '1;

	typedef enum logic [1:0] {
		POP_STEADY,
		POP_COIN,
		POP_SPARSE,
		POP_PATTERN
	} pop_mode_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        push = 1'b0;
	logic        pop = 1'b0;
	op_t         op = OP_KEY1;
	logic [63:0] key = '0;
	logic        full;
	logic        empty;
	logic        group_valid;
	logic [63:0] group_key;
	logic [31:0] group_count;
	logic [1:0]  need_stream;
	logic        done_res;
	logic        error;

	union_checker expected_union = new();

	int          burst_left = 0;
	int          idle_cycles = 0;
	logic [63:0] last_key [2];
	pop_mode_t   pop_mode = POP_STEADY;
	int          mode_left = 0;
	logic [7:0]  pop_bits = '1;

	sorted_merge_bag_union i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.op          (op),
		.key         (key),
		.empty       (empty),
		.pop         (pop),
		.group_valid (group_valid),
		.group_key   (group_key),
		.group_count (group_count),
		.need_stream (need_stream),
		.done_res    (done_res),
		.error       (error)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic op_t stream_op(int s, bit is_end);
		if (is_end)
			return (s == 1) ? OP_END2 : OP_END1;
		return (s == 1) ? OP_KEY2 : OP_KEY1;
	endfunction

	// mostly ascending keys with duplicates; a lagging stream catches up to the leader
	function automatic logic [63:0] next_stream_key(int s);
		logic [63:0] lead;
		logic [63:0] k;
		int          pick;
		lead = (last_key[0] > last_key[1]) ? last_key[0] : last_key[1];
		pick = $urandom_range(0, 99);
		if (last_key[s] + 64 < lead && $urandom_range(0, 3) == 0)
			k = lead - $urandom_range(0, 16);
		else if (pick < 25)
			k = last_key[s];
		else if (pick < 85)
			k = last_key[s] + $urandom_range(1, 3);
		else if (pick < 95)
			k = last_key[s] + $urandom_range(4, 1000);
		else if (pick < 98)
			k = lead + $urandom_range(1, 1 << 30);
		else
			k = (last_key[s] > 4) ? last_key[s] - $urandom_range(1, 4) : last_key[s];
		last_key[s] = k;
		return k;
	endfunction

	// one request: optional gap at a burst boundary, then hold push until taken
	task automatic send_request(input op_t o, input logic [63:0] k);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
			repeat (gap) begin
				@(negedge clk);
				push <= 1'b0;
			end
			burst_left = $urandom_range(1, 24);
		end
		burst_left--;
		@(negedge clk);
		push <= 1'b1;
		op <= o;
		key <= k;
		@(posedge clk);
		while (full !== 1'b0)
			@(posedge clk);
		expected_union.note_request(o, k);
	endtask

	always @(negedge clk) begin
		if (mode_left == 0) begin
			pop_mode = pop_mode_t'($urandom_range(0, 3));
			mode_left = $urandom_range(20, 200);
			pop_bits = 8'($urandom);
			if (pop_bits == 8'h00)
				pop_bits = 8'h01;
		end
		mode_left--;
		case (pop_mode)
			POP_STEADY: pop <= 1'b1;
			POP_COIN: pop <= 1'($urandom_range(0, 1));
			POP_SPARSE: pop <= ($urandom_range(0, 3) == 0);
			default: begin
				pop <= pop_bits[0];
				pop_bits = {pop_bits[0], pop_bits[7:1]};
			end
		endcase
	end

	always @(posedge clk) begin
		union_result_t got;
		if (arst_n && pop && !empty) begin
			got.grp_valid = group_valid;
			got.grp_key = group_key;
			got.grp_count = group_count;
			got.need = need_t'(need_stream);
			got.done = done_res;
			got.err = error;
			expected_union.check_result(got);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (push && !full) || (pop && !empty)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		logic [63:0] k;
		need_t       want;
		int          s;
		int          accepted_keys;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// opening: full heads, ties, zero keys and an out of order key
		send_request(OP_KEY1, 64'd0);
		send_request(OP_KEY1, KEY_MAX);
		send_request(OP_END1, 64'h5a5a_a5a5_0f0f_f0f0);
		send_request(OP_KEY2, 64'd0);
		send_request(OP_END2, 64'd0);
		send_request(OP_KEY2, 64'd9);
		send_request(OP_KEY1, 64'd0);
		send_request(OP_KEY1, 64'd1);
		send_request(OP_KEY2, 64'd1);
		send_request(OP_KEY1, 64'd1);
		send_request(OP_KEY1, 64'd3);
		send_request(OP_KEY2, 64'd2);
		send_request(OP_KEY2, 64'd1);
		send_request(OP_KEY2, 64'd5);
		send_request(OP_KEY1, 64'd5);
		last_key[0] = 64'd5;
		last_key[1] = 64'd5;

		// feed whichever stream is asked for, with some requests aimed at a full head
		accepted_keys = 0;
		while (accepted_keys < RANDOM_KEYS) begin
			want = expected_union.wanted_stream();
			s = (want == NEED_SECOND) ? 1 : 0;
			if ($urandom_range(0, 9) == 0 && expected_union.holds_key(1 - s)) begin
				send_request(stream_op(1 - s, 1'($urandom_range(0, 1))), {$urandom, $urandom});
			end else begin
				send_request(stream_op(s, 1'b0), next_stream_key(s));
				accepted_keys++;
			end
		end

		// close the first stream, run the second one alone up to the largest key
		while (expected_union.wanted_stream() != NEED_FIRST)
			send_request(OP_KEY2, next_stream_key(1));
		send_request(OP_END1, {$urandom, $urandom});
		send_request(OP_KEY1, {$urandom, $urandom});
		send_request(OP_END1, 64'd0);
		k = {1'b1, 31'($urandom), 32'($urandom)};
		send_request(OP_KEY2, k);
		send_request(OP_KEY2, k);
		send_request(OP_KEY2, KEY_MAX - 1);
		send_request(OP_KEY2, KEY_MAX);
		send_request(OP_KEY2, KEY_MAX);
		send_request(OP_END2, {$urandom, $urandom});
		// everything after the finish is refused
		send_request(OP_KEY1, {$urandom, $urandom});
		send_request(OP_KEY2, KEY_MAX);
		send_request(OP_END1, {$urandom, $urandom});
		send_request(OP_END2, {$urandom, $urandom});
		@(negedge clk);
		push <= 1'b0;

		while (expected_union.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (expected_union.mismatches == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
